FILE: design/kcl_pkg.sv
package kcl_pkg;

   localparam int CODE_DIGITS = 4;
   localparam int CODE_W      = 4 * CODE_DIGITS;
   localparam int LEN_W       = $clog2(CODE_DIGITS + 1);

   localparam logic [3:0] KEY_STAR  = 4'd10;
   localparam logic [3:0] KEY_HASH  = 4'd11;
   localparam logic [3:0] KEY_NONE  = 4'd15;
   localparam logic [3:0] GUESS_MAX = 4'd15;
   localparam logic [1:0] HASH_TO_REGISTER = 2'd3;

   localparam logic       OP_KEY     = 1'b0;
   localparam logic       OP_PRELOAD = 1'b1;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_UNLOCKED   = 3'd1;
   localparam logic [2:0] EV_WRONG      = 3'd2;
   localparam logic [2:0] EV_REGISTERED = 3'd3;
   localparam logic [2:0] EV_FULL       = 3'd4;
   localparam logic [2:0] EV_RESET      = 3'd5;
   localparam logic [2:0] EV_HASH       = 3'd6;

   localparam logic [1:0] CSR_RELOCK_TIME = 2'd0;
   localparam logic [1:0] CSR_STALE_TIME  = 2'd1;
   localparam logic [1:0] CSR_GUESS_LIMIT = 2'd2;

   localparam logic [31:0] RELOCK_TIME_RST = 32'd5000;
   localparam logic [31:0] STALE_TIME_RST  = 32'd10000;
   localparam logic [3:0]  GUESS_LIMIT_RST = 4'd3;

   typedef struct packed {
      logic        operation;
      logic [3:0]  key_code;
      logic [31:0] now_ms;
      logic [15:0] preload_code;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic       alarm_on;
      logic       registering;
      logic [2:0] digits_entered;
      logic [3:0] failed_guesses;
      logic [1:0] hash_presses;
      logic [3:0] user_index;
      logic [4:0] codes_stored;
      logic [2:0] event_res;
      logic       display_changed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic srch_clr;
      logic srch_step;
      logic commit;
      logic use_hit;
   } cmd_type;

   typedef struct packed {
      logic is_search;
      logic match;
      logic last;
      logic out_free;
   } sts_type;

endpackage

FILE: design/kcl_ctrl.sv
module kcl_ctrl
   import kcl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECODE = 3'b010,
      S_SEARCH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.srch_clr = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_search) begin
               cmd.srch_step = 1'b1;
               state_in      = S_SEARCH;
            end else if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (sts.match || sts.last) begin
               if (sts.out_free) begin
                  cmd.commit  = 1'b1;
                  cmd.use_hit = 1'b1;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while result register occupied");

   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("not idle after commit");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("accepted a second transaction during work");

endmodule

FILE: design/kcl_dpath.sv
module kcl_dpath
   import kcl_pkg::*;
#(
   parameter int MAX_CODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IW    = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
   localparam int CW    = $clog2(MAX_CODES + 1);
   localparam int DEPTH = 1 << IW;

   logic [CODE_W-1:0] code_mem [0:DEPTH-1];

   logic [31:0]       relock_time_ff;
   logic [31:0]       stale_time_ff;
   logic [3:0]        guess_limit_ff;

   req_type           item_ff;
   logic              mode_reg_ff, mode_reg_in;
   logic              locked_ff, locked_in;
   logic              alarm_ff, alarm_in;
   logic [3:0]        guess_ff, guess_in;
   logic [CODE_W-1:0] entry_ff, entry_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [1:0]        hash_ff, hash_in;
   logic [31:0]       opened_ff, opened_in;
   logic [31:0]       last_key_ff, last_key_in;
   logic [IW-1:0]     user_ff, user_in;
   logic [CW-1:0]     count_ff, count_in;

   logic [IW-1:0]     srch_idx_ff;
   logic [IW-1:0]     cmp_idx_ff;
   logic [CODE_W-1:0] rd_data_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [CODE_W-1:0] wr_data;
   logic              hit;
   logic              room;
   logic [31:0]       open_age;
   logic [31:0]       key_age;
   logic              stale;
   logic              do_relock;
   logic              disp;
   logic [2:0]        ev;
   logic [3:0]        guess_up;
   logic [1:0]        hash_up;
   logic [31:0]       user_wide;
   logic [31:0]       count_wide;
   logic [31:0]       len_wide;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         relock_time_ff <= RELOCK_TIME_RST;
         stale_time_ff  <= STALE_TIME_RST;
         guess_limit_ff <= GUESS_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_RELOCK_TIME: relock_time_ff <= csr_wdata;
            CSR_STALE_TIME:  stale_time_ff  <= csr_wdata;
            CSR_GUESS_LIMIT: guess_limit_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   // code table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[count_ff[IW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.srch_step) begin
         rd_data_ff <= code_mem[srch_idx_ff];
         cmp_idx_ff <= srch_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.srch_clr) begin
         srch_idx_ff <= '0;
      end else if (cmd.srch_step) begin
         srch_idx_ff <= srch_idx_ff + IW'(1);
      end
   end

   assign room = count_ff < CW'(MAX_CODES);

   always_comb begin
      sts.is_search = (item_ff.operation == OP_KEY) && (item_ff.key_code == KEY_HASH) &&
                      (len_ff == LEN_W'(CODE_DIGITS)) && !mode_reg_ff &&
                      (count_ff != '0);
      sts.match     = (rd_data_ff == entry_ff);
      sts.last      = ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign hit      = cmd.use_hit && sts.match;
   assign open_age = item_ff.now_ms - opened_ff;
   assign key_age  = item_ff.now_ms - last_key_ff;
   assign stale    = key_age > stale_time_ff;
   assign guess_up = (guess_ff < GUESS_MAX) ? guess_ff + 4'd1 : guess_ff;
   assign hash_up  = hash_ff + 2'd1;

   // step update
   always_comb begin
      mode_reg_in = mode_reg_ff;
      locked_in   = locked_ff;
      alarm_in    = alarm_ff;
      guess_in    = guess_ff;
      entry_in    = entry_ff;
      len_in      = len_ff;
      hash_in     = hash_ff;
      opened_in   = opened_ff;
      last_key_in = last_key_ff;
      user_in     = user_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_data     = entry_ff;
      do_relock   = 1'b0;
      disp        = 1'b0;
      ev          = EV_NONE;

      if (item_ff.operation == OP_PRELOAD) begin
         if (room) begin
            wr_en    = cmd.commit;
            wr_data  = item_ff.preload_code[CODE_W-1:0];
            count_in = count_ff + CW'(1);
            ev       = EV_REGISTERED;
         end else begin
            ev = EV_FULL;
         end
         mode_reg_in = 1'b0;
      end else if (item_ff.key_code == KEY_NONE) begin
         if (!mode_reg_ff) begin
            do_relock = (!locked_ff && (open_age > relock_time_ff)) || stale;
         end else if (stale) begin
            mode_reg_in = 1'b0;
            do_relock   = 1'b1;
         end
         if (do_relock) begin
            disp      = (len_ff != '0) || !locked_ff;
            entry_in  = '0;
            len_in    = '0;
            locked_in = 1'b1;
            guess_in  = '0;
            opened_in = '0;
            ev        = EV_RESET;
         end
      end else begin
         last_key_in = item_ff.now_ms;
         if (item_ff.key_code == KEY_STAR) begin
            entry_in = '0;
            len_in   = '0;
            disp     = 1'b1;
         end else if (item_ff.key_code inside {[4'd0:4'd9]}) begin
            if (len_ff < LEN_W'(CODE_DIGITS)) begin
               entry_in = {entry_ff[CODE_W-5:0], item_ff.key_code};
               len_in   = len_ff + LEN_W'(1);
               disp     = 1'b1;
            end
         end else if (item_ff.key_code == KEY_HASH && len_ff == LEN_W'(CODE_DIGITS)) begin
            disp     = 1'b1;
            entry_in = '0;
            len_in   = '0;
            if (!mode_reg_ff) begin
               if (hit) begin
                  locked_in = 1'b0;
                  guess_in  = '0;
                  user_in   = cmp_idx_ff;
                  opened_in = item_ff.now_ms;
                  alarm_in  = 1'b0;
                  hash_in   = '0;
                  ev        = EV_UNLOCKED;
               end else begin
                  ev = EV_WRONG;
                  if (locked_ff) begin
                     guess_in = guess_up;
                     if (guess_up >= guess_limit_ff) begin
                        alarm_in = 1'b1;
                     end
                  end
               end
            end else begin
               if (room) begin
                  wr_en    = cmd.commit;
                  count_in = count_ff + CW'(1);
                  ev       = EV_REGISTERED;
               end else begin
                  ev = EV_FULL;
               end
               mode_reg_in = 1'b0;
               locked_in   = 1'b1;
               guess_in    = '0;
               opened_in   = '0;
            end
         end else if (!locked_ff && item_ff.key_code == KEY_HASH && len_ff == '0) begin
            opened_in = item_ff.now_ms;
            disp      = 1'b1;
            ev        = EV_HASH;
            if (hash_up == HASH_TO_REGISTER) begin
               mode_reg_in = 1'b1;
               hash_in     = '0;
            end else begin
               hash_in = hash_up;
            end
         end
      end
   end

   assign user_wide  = 32'(user_in);
   assign count_wide = 32'(count_in);
   assign len_wide   = 32'(len_in);

   always_comb begin
      rsp_in.relay_on        = !locked_in;
      rsp_in.alarm_on        = alarm_in;
      rsp_in.registering     = mode_reg_in;
      rsp_in.digits_entered  = len_wide[2:0];
      rsp_in.failed_guesses  = guess_in;
      rsp_in.hash_presses    = hash_in;
      rsp_in.user_index      = user_wide[3:0];
      rsp_in.codes_stored    = count_wide[4:0];
      rsp_in.event_res       = ev;
      rsp_in.display_changed = disp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_reg_ff <= 1'b1;
         locked_ff   <= 1'b1;
         alarm_ff    <= 1'b0;
         guess_ff    <= '0;
         entry_ff    <= '0;
         len_ff      <= '0;
         hash_ff     <= '0;
         opened_ff   <= '0;
         last_key_ff <= '0;
         user_ff     <= '0;
         count_ff    <= '0;
      end else if (cmd.commit) begin
         mode_reg_ff <= mode_reg_in;
         locked_ff   <= locked_in;
         alarm_ff    <= alarm_in;
         guess_ff    <= guess_in;
         entry_ff    <= entry_in;
         len_ff      <= len_in;
         hash_ff     <= hash_in;
         opened_ff   <= opened_in;
         last_key_ff <= last_key_in;
         user_ff     <= user_in;
         count_ff    <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_CODES))
      else $error("code count beyond table depth");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CODE_DIGITS))
      else $error("entry length beyond code digits");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result not presented after commit");

endmodule

FILE: design/keypad_code_lock_top.sv
// An accepted transaction is registered, decoded and committed to the result register.
// A full entry confirmed with hash outside registering mode first searches the code
// table, up to MAX_CODES entries, one entry per cycle from its single read port.
// No new transaction is taken until commit; commit waits while a result is pending.
// Reset: synchronous, active high; registering mode, locked, counts cleared and
// timeouts back to 5000 ms / 10000 ms, guess limit 3. Table contents are not cleared.
module keypad_code_lock_top
   import kcl_pkg::*;
#(
   parameter int MAX_CODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   kcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kcl_dpath #(
      .MAX_CODES (MAX_CODES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
